### hw/rtl/qnorm_pkg.sv
// Package for the quaternion normaliser: default widths and the lane count.
`timescale 1ns / 1ps
`default_nettype none
package qnorm_pkg;
  localparam int unsigned COMP_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 14;
  localparam int unsigned LANES          = 4;
endpackage
`default_nettype wire

### hw/rtl/quaternion_normalize.sv
// Pipeline: squaring, sum of squares, root pipeline, divider lanes, output register.
// Throughput: one quaternion per cycle unless stalled; the squaring, the root
// pipeline and four divider lanes are fully pipelined and advance together.
// Backpressure stalls the whole pipeline; an output register holds the result.
// Reset (rst_ni low, asynchronous) clears all valid bits; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_normalize import qnorm_pkg::*; #(
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // in_w, in_x, in_y, in_z from lowest bit
  input  wire logic [((4*COMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // out_w, out_x, out_y, out_z from lowest bit
  output logic [((4*COMP_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // zero_length
  output logic      m_axis_tuser
);
  localparam int unsigned PW  = 2 * COMP_WIDTH;
  localparam int unsigned SW  = 2 * (COMP_WIDTH + 1);   // even, holds sum
  localparam int unsigned RW  = COMP_WIDTH + 1;
  localparam int unsigned QW  = COMP_WIDTH + FRAC_BITS;
  localparam int unsigned TW  = LANES * COMP_WIDTH;
  localparam int unsigned LAT = 3 + RW + QW;
  localparam int unsigned DW  = ((4*COMP_WIDTH+7)/8)*8;

  logic en;
  logic [LAT-1:0] vld_q;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // squaring lanes
  logic signed [COMP_WIDTH-1:0] c [LANES];
  logic [PW-1:0] sq_q [LANES];
  logic [TW-1:0] c1_q, c2_q;
  logic [SW-1:0] sum_q;
  for (genvar l = 0; l < LANES; l++) begin : g_sq
    assign c[l] = s_axis_tdata[l*COMP_WIDTH +: COMP_WIDTH];
    always_ff @(posedge clk_i) begin
      if (en) sq_q[l] <= PW'($signed(c[l]) * $signed(c[l]));
    end
  end
  // merge: sum of squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q  <= s_axis_tdata[TW-1:0];
      c2_q  <= c1_q;
      sum_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]) + SW'(sq_q[3]);
    end
  end

  logic [RW-1:0] len;
  logic [TW-1:0] c3;
  qnorm_sqrt #(.SW(SW), .RW(RW), .TW(TW)) u_sqrt (
    .clk_i, .en_i(en), .sum_i(sum_q), .tag_i(c2_q),
    .root_o(len), .tag_o(c3)
  );

  // zero flag follows the divider pipeline
  logic [QW-1:0] zl_q;
  always_ff @(posedge clk_i) begin
    if (en) zl_q <= {zl_q[QW-2:0], (len == '0)};
  end

  logic [DW-1:0] res;
  always_comb begin
    res = '0;
  end
  logic [COMP_WIDTH-1:0] q [LANES];
  for (genvar l = 0; l < LANES; l++) begin : g_div
    qnorm_div #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS), .RW(RW)) u_div (
      .clk_i, .en_i(en), .comp_i(c3[l*COMP_WIDTH +: COMP_WIDTH]),
      .len_i(len), .quot_o(q[l])
    );
  end

  // output register
  logic [DW-1:0] out_q;
  logic          zo_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res | DW'({q[3], q[2], q[1], q[0]});
      zo_q  <= zl_q[QW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = zo_q;
endmodule
`default_nettype wire

### hw/rtl/qnorm_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qnorm_sqrt import qnorm_pkg::*; #(
  parameter int unsigned SW = 34,
  parameter int unsigned RW = 17,
  parameter int unsigned TW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [SW-1:0] sum_i,
  input  wire logic [TW-1:0] tag_i,
  output logic [RW-1:0]      root_o,
  output logic [TW-1:0]      tag_o
);
  // per stage: remaining value, partial root, carried tag
  logic [SW+1:0] rem_q  [RW+1];
  logic [RW-1:0] root_q [RW+1];
  logic [TW-1:0] tag_q  [RW+1];
  logic [SW+1:0] src_q  [RW+1];

  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign tag_q[0]  = tag_i;
  assign src_q[0]  = {2'b00, sum_i};

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [SW+1:0] rem_d, src_d, trial;
    logic [RW-1:0] root_d;
    logic [SW+1:0] r_q, s_q;
    logic [RW-1:0] ro_q;
    logic [TW-1:0] t_q;
    // restoring step: bring down two bits, try 4r+1
    always_comb begin
      rem_d  = {rem_q[s][SW-1:0], src_q[s][2*RW-1 -: 2]};
      trial  = {{(SW+2-RW-2){1'b0}}, root_q[s], 2'b01};
      src_d  = {src_q[s][SW-1:0], 2'b00};
      root_d = {root_q[s][RW-2:0], 1'b0};
      if (rem_d >= trial) begin
        rem_d     = rem_d - trial;
        root_d[0] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q  <= rem_d;
        s_q  <= src_d;
        ro_q <= root_d;
        t_q  <= tag_q[s];
      end
    end
    assign rem_q[s+1]  = r_q;
    assign src_q[s+1]  = s_q;
    assign root_q[s+1] = ro_q;
    assign tag_q[s+1]  = t_q;
  end

  assign root_o = root_q[RW];
  assign tag_o  = tag_q[RW];
endmodule
`default_nettype wire

### hw/rtl/qnorm_div.sv
// One divider lane: pipelined restoring division of |c|<<FRAC by length.
`timescale 1ns / 1ps
`default_nettype none
module qnorm_div import qnorm_pkg::*; #(
  parameter int unsigned COMP_WIDTH = COMP_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned RW         = COMP_WIDTH + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [COMP_WIDTH-1:0] comp_i,
  input  wire logic [RW-1:0]         len_i,
  output logic [COMP_WIDTH-1:0]      quot_o
);
  localparam int unsigned NW = COMP_WIDTH + FRAC_BITS;  // dividend bits
  localparam int unsigned QW = NW;

  logic [NW-1:0] num_s [QW+1];
  logic [RW:0]   rem_s [QW+1];
  logic [QW-1:0] quo_s [QW+1];
  logic [RW-1:0] den_s [QW+1];
  logic          neg_s [QW+1];
  logic [COMP_WIDTH-1:0] raw_s [QW+1];
  logic [COMP_WIDTH-1:0] mag;

  assign mag = comp_i[COMP_WIDTH-1] ? (~comp_i + 1'b1) : comp_i;
  assign num_s[0] = {mag, {FRAC_BITS{1'b0}}};
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign den_s[0] = len_i;
  assign neg_s[0] = comp_i[COMP_WIDTH-1];
  assign raw_s[0] = comp_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RW:0] sh, rd;
    logic qb;
    logic [NW-1:0] n_q;
    logic [RW:0] r_q;
    logic [QW-1:0] q_q;
    logic [RW-1:0] d_q;
    logic ng_q;
    logic [COMP_WIDTH-1:0] w_q;
    // shift in next dividend bit, subtract when it fits
    always_comb begin
      sh = {rem_s[s][RW-1:0], num_s[s][NW-1]};
      qb = (sh >= {1'b0, den_s[s]});
      rd = qb ? sh - {1'b0, den_s[s]} : sh;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q  <= {num_s[s][NW-2:0], 1'b0};
        r_q  <= rd;
        q_q  <= {quo_s[s][QW-2:0], qb};
        d_q  <= den_s[s];
        ng_q <= neg_s[s];
        w_q  <= raw_s[s];
      end
    end
    assign num_s[s+1] = n_q;
    assign rem_s[s+1] = r_q;
    assign quo_s[s+1] = q_q;
    assign den_s[s+1] = d_q;
    assign neg_s[s+1] = ng_q;
    assign raw_s[s+1] = w_q;
  end

  // saturate and restore sign; zero length passes the raw component
  localparam logic [QW-1:0] PMAX = QW'((64'd1 << (COMP_WIDTH - 1)) - 64'd1);
  localparam logic [QW-1:0] NMAX = QW'(64'd1 << (COMP_WIDTH - 1));
  logic [QW-1:0] q_sat;
  always_comb begin
    if (den_s[QW] == '0) begin
      q_sat  = '0;
      quot_o = raw_s[QW];
    end else if (neg_s[QW]) begin
      q_sat  = (quo_s[QW] > NMAX) ? NMAX : quo_s[QW];
      quot_o = COMP_WIDTH'(~q_sat + 1'b1);
    end else begin
      q_sat  = (quo_s[QW] > PMAX) ? PMAX : quo_s[QW];
      quot_o = q_sat[COMP_WIDTH-1:0];
    end
  end
endmodule
`default_nettype wire

### bench/tb_quaternion_normalize.sv
// Testbench for the quaternion normaliser: directed and random quaternions checked against a model.
`timescale 1ns / 1ps
module tb_quaternion_normalize;
  import qnorm_pkg::*;

  localparam int CW = COMP_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int DW = ((4*CW+7)/8)*8;
  localparam int LATENCY = 3 + (CW+1) + (CW+FB);
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [CW-1:0] z, y, x, w;
  } quat_t;

  typedef struct packed {
    quat_t q;
    logic  zero_len;
  } norm_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic m_axis_tuser;

  quaternion_normalize i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  norm_t norm_queue[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Floor square root of a sum of squares (below 2^34)
  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // Expected normalised quaternion
  function automatic norm_t normalise(quat_t q);
    norm_t res;
    longint c[4];
    longint unsigned s, len, a, qq;
    c[0] = longint'($signed(q.w));
    c[1] = longint'($signed(q.x));
    c[2] = longint'($signed(q.y));
    c[3] = longint'($signed(q.z));
    s = 0;
    for (int i = 0; i < 4; i++) s += longint'(c[i] * c[i]);
    res.q = q;
    res.zero_len = 1'b1;
    if (s != 0) begin
      res.zero_len = 1'b0;
      len = root_floor(s);
      for (int i = 0; i < 4; i++) begin
        a = (c[i] < 0) ? -c[i] : c[i];
        qq = (a << FB) / len;
        if (c[i] < 0) begin
          if (qq > (64'd1 << (CW-1))) qq = 64'd1 << (CW-1);
          qq = -qq;
        end else if (qq > (64'd1 << (CW-1)) - 1) begin
          qq = (64'd1 << (CW-1)) - 1;
        end
        case (i)
          0: res.q.w = qq[CW-1:0];
          1: res.q.x = qq[CW-1:0];
          2: res.q.y = qq[CW-1:0];
          default: res.q.z = qq[CW-1:0];
        endcase
      end
    end
    return res;
  endfunction

  // Send one request; driven at the falling edge
  task automatic send_quat(quat_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= DW'(q);
    s_axis_tvalid <= 1'b1;
    norm_queue.push_back(normalise(q));
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Receiver readiness with random stalls
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    norm_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.q = quat_t'(m_axis_tdata[4*CW-1:0]);
      got.zero_len = m_axis_tuser;
      if (norm_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = norm_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected w%h x%h y%h z%h zl%b, got w%h x%h y%h z%h zl%b",
                     want.q.w, want.q.x, want.q.y, want.q.z, want.zero_len,
                     got.q.w, got.q.x, got.q.y, got.q.z, got.zero_len);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return CW'($urandom_range(7)) - CW'(3);
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return {1'b0, {(CW-1){1'b1}}};
      default: return CW'($urandom);
    endcase
  endfunction

  // Extremes, zero length, single axes and signs
  task automatic test_directed();
    logic [CW-1:0] mn, mx, one;
    mn = {1'b1, {(CW-1){1'b0}}};
    mx = {1'b0, {(CW-1){1'b1}}};
    one = CW'(1) << FB;
    send_quat('{z: 0, y: 0, x: 0, w: 0});
    send_quat('{z: 0, y: 0, x: 0, w: one});
    send_quat('{z: 0, y: 0, x: -one, w: 0});
    send_quat('{z: 0, y: 1, x: 0, w: 0});
    send_quat('{z: -1, y: 0, x: 0, w: 0});
    send_quat('{z: mn, y: mn, x: mn, w: mn});
    send_quat('{z: mx, y: mx, x: mx, w: mx});
    send_quat('{z: mn, y: 0, x: 0, w: 0});
    send_quat('{z: 0, y: 0, x: 0, w: mx});
    send_quat('{z: mx, y: mn, x: mx, w: mn});
    send_quat('{z: 1, y: 1, x: 1, w: 1});
    send_quat('{z: -1, y: -1, x: -1, w: -1});
    send_quat('{z: 0, y: 0, x: 1, w: mn});
    send_quat('{z: CW'(16'h5555), y: CW'(16'haaaa), x: CW'(16'h0f0f), w: CW'(16'hf0f0)});
  endtask

  // Random quaternions; the main sequence runs this under three idling regimes
  task automatic test_random(int unsigned n);
    quat_t q;
    for (int i = 0; i < n; i++) begin
      q.w = rand_comp(); q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp();
      if ($urandom_range(30) == 0) q = '0;
      send_quat(q);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (norm_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 35; recv_idle_pct = 52;
    test_directed();
    test_random(230);
    send_idle_pct = 52; recv_idle_pct = 35;
    test_random(230);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(240);
    drain();
    if (mismatches == 0 && norm_queue.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

### quaternion_normalize.f
hw/rtl/qnorm_pkg.sv
hw/rtl/qnorm_sqrt.sv
hw/rtl/qnorm_div.sv
hw/rtl/quaternion_normalize.sv
bench/tb_quaternion_normalize.sv
